// ===== sv/arbu_pkg.sv =====
package arbu_pkg;

    localparam int DIST_W    = 16;
    localparam int SPK_IN_W  = 16;
    localparam int OCC_IN_W  = 24;
    localparam int SPK_W     = 28;
    localparam int OCC_W     = 36;
    localparam int RSQ_W     = 8;
    localparam int ALPHA_W   = 32;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int K_W       = 36;
    localparam int P2_W      = 57;
    localparam int ACC_W     = 91;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // register index sits at paddr[2]
    localparam logic REG_ALPHA = 1'b0;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 32'h0001_0000;

    localparam logic [SPK_W-1:0]  SPK_MAX  = {SPK_W{1'b1}};
    localparam logic [OCC_W-1:0]  OCC_MAX  = {OCC_W{1'b1}};
    localparam logic [OCC_W-1:0]  OCC_ONE  = 36'h0_1000_0000;
    localparam logic [PROD_W-1:0] PROD_ONE = 64'h0000_0000_1000_0000;
    localparam logic [ACC_W-1:0]  ACC_LIM  = {{(ACC_W-57){1'b0}}, 1'b1, 56'b0};

    typedef struct packed {
        logic [DIST_W-1:0]   distance;
        logic [SPK_IN_W-1:0] spikes;
        logic [OCC_IN_W-1:0] occ;
    } t_cell;

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PASS,
        ST_DRAIN,
        ST_K,
        ST_M1,
        ST_P2,
        ST_PP0,
        ST_PP1,
        ST_PP2,
        ST_PP3,
        ST_PP4
    } t_state;

endpackage

// ===== sv/adaptive_radius_binning_unit.sv =====
// channel   | signals                                           | handshake
// ----------+---------------------------------------------------+------------------------
// cell in   | i_distance, i_spikes, i_occupancy, i_last         | start high, busy low
// result    | o_spike_sum, o_occupancy_sum, o_criterion_met,    | o_done, one cycle
//           | o_final_radius_sq                                 |
// config    | psel, penable, pwrite, paddr, pwdata, prdata      | APB, pready tied high
//
// A cell without last is stored; busy stays low.
// A last cell starts the search: each radius pass streams all N stored cells through
// the cell memory read port and the shared 32x32 multiplier, then the criterion runs
// as up to 8 steps of the same multiplier. The search runs at most RADIUS_SQ_LIMIT
// passes; the result strobe follows the last pass.
// Reset is synchronous; the cell memory is not cleared. Results cannot be stalled.
module adaptive_radius_binning_unit
    import arbu_pkg::*;
#(
    parameter int GRID_CELLS      = 4096,
    parameter int RADIUS_SQ_LIMIT = 200
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                start,
    output logic                busy,
    input  logic [DIST_W-1:0]   i_distance,
    input  logic [SPK_IN_W-1:0] i_spikes,
    input  logic [OCC_IN_W-1:0] i_occupancy,
    input  logic                i_last,

    output logic                o_done,
    output logic [SPK_W-1:0]    o_spike_sum,
    output logic [OCC_W-1:0]    o_occupancy_sum,
    output logic                o_criterion_met,
    output logic [RSQ_W-1:0]    o_final_radius_sq,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int CW = $clog2(GRID_CELLS + 1);
    localparam int AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;

    t_state r_state, n_state;

    logic [ALPHA_W-1:0] r_alpha;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_rd;
    logic               r_v1, r_v2;
    logic [RSQ_W-1:0]   r_rsq;
    logic [SPK_W-1:0]   r_fb;
    logic [SPK_W-1:0]   r_spk;
    logic [OCC_W-1:0]   r_occ;
    logic [SPK_IN_W-1:0] r_s2_spk;
    logic [OCC_IN_W-1:0] r_s2_occ;
    logic [K_W-1:0]     r_k;
    logic [P2_W-1:0]    r_p2;
    logic [ACC_W-1:0]   r_acc;
    logic               r_done;
    logic [SPK_W-1:0]   r_out_spk;
    logic [OCC_W-1:0]   r_out_occ;
    logic               r_out_met;
    logic [RSQ_W-1:0]   r_out_rsq;

    logic               accept;
    logic               full;
    logic               rd_en;
    logic               last_issue;
    logic               drained;
    logic               rsq_last;
    logic               crit_done;
    logic               crit_met;
    logic               finish;
    logic               in_range;
    logic [SPK_W:0]     spk_add;
    logic [OCC_W:0]     occ_add;
    logic [SPK_W-1:0]   spk_next;
    logic [OCC_W-1:0]   occ_next;
    t_mul_req           mul_req;
    logic [PROD_W-1:0]  prod;
    t_cell              wr_cell;
    t_cell              rd_cell;
    logic               cfg_wr;

    assign accept     = start && !busy;
    assign full       = (r_count == CW'(GRID_CELLS));
    assign last_issue = (r_rd == r_count - 1'b1);
    assign drained    = !r_v1 && !r_v2;
    assign rsq_last   = (({1'b0, r_rsq} + 9'd1) >= 9'(RADIUS_SQ_LIMIT));
    assign finish     = crit_done && (crit_met || rsq_last);

    assign wr_cell.distance = i_distance;
    assign wr_cell.spikes   = i_spikes;
    assign wr_cell.occ      = i_occupancy;

    arbu_cell_mem #(
        .DEPTH (GRID_CELLS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (accept && !full),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_cell (wr_cell),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd[AW-1:0]),
        .o_rd_cell (rd_cell)
    );

    arbu_mult u_mult (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    // cell test and saturating sums, stage two of the pass pipeline
    assign in_range = (prod[31:0] <= {8'b0, r_rsq, 16'b0});
    assign spk_add  = {1'b0, r_spk} + (SPK_W + 1)'(r_s2_spk);
    assign occ_add  = {1'b0, r_occ} + (OCC_W + 1)'(r_s2_occ);
    assign spk_next = spk_add[SPK_W] ? SPK_MAX : spk_add[SPK_W-1:0];
    assign occ_next = occ_add[OCC_W] ? OCC_MAX : occ_add[OCC_W-1:0];

    // criterion: (alpha*occ)^2 * rsq * fb > 2^56, exact
    always_comb begin
        crit_done = 1'b0;
        crit_met  = 1'b0;
        case (r_state)
            ST_K: begin
                if (r_alpha == '0 || r_occ == '0 || r_rsq == '0 || r_fb == '0) begin
                    crit_done = 1'b1;
                end else if (r_occ > OCC_ONE) begin
                    crit_done = 1'b1;
                    crit_met  = 1'b1;
                end
            end
            ST_P2: begin
                if (prod > PROD_ONE) begin
                    crit_done = 1'b1;
                    crit_met  = 1'b1;
                end
            end
            ST_PP4: begin
                crit_done = 1'b1;
                crit_met  = (prod != '0) || (r_acc > ACC_LIM);
            end
            default: begin
                crit_done = 1'b0;
                crit_met  = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept && i_last) n_state = ST_PASS;
            ST_PASS:  if (last_issue) n_state = ST_DRAIN;
            ST_DRAIN: if (drained) n_state = ST_K;
            ST_K:     n_state = crit_done ? (finish ? ST_IDLE : ST_PASS) : ST_M1;
            ST_M1:    n_state = ST_P2;
            ST_P2:    n_state = crit_done ? (finish ? ST_IDLE : ST_PASS) : ST_PP0;
            ST_PP0:   n_state = ST_PP1;
            ST_PP1:   n_state = ST_PP2;
            ST_PP2:   n_state = ST_PP3;
            ST_PP3:   n_state = ST_PP4;
            ST_PP4:   n_state = finish ? ST_IDLE : ST_PASS;
            default:  n_state = ST_IDLE;
        endcase
    end

    // multiplier operands: cell squares during a pass, criterion steps after it
    always_comb begin
        busy    = (r_state != ST_IDLE);
        rd_en   = (r_state == ST_PASS);
        mul_req = '0;
        if (r_v1) begin
            mul_req.a = MUL_W'(rd_cell.distance);
            mul_req.b = MUL_W'(rd_cell.distance);
        end else begin
            unique case (r_state)
                ST_K: begin
                    mul_req.a = MUL_W'(r_rsq);
                    mul_req.b = MUL_W'(r_fb);
                end
                ST_M1: begin
                    mul_req.a = r_alpha;
                    mul_req.b = r_occ[31:0];
                end
                ST_P2: begin
                    mul_req.a = prod[31:0];
                    mul_req.b = prod[31:0];
                end
                ST_PP0: begin
                    mul_req.a = prod[31:0];
                    mul_req.b = r_k[31:0];
                end
                ST_PP1: begin
                    mul_req.a = MUL_W'(r_p2[P2_W-1:32]);
                    mul_req.b = r_k[31:0];
                end
                ST_PP2: begin
                    mul_req.a = r_p2[31:0];
                    mul_req.b = MUL_W'(r_k[K_W-1:32]);
                end
                ST_PP3: begin
                    mul_req.a = MUL_W'(r_p2[P2_W-1:32]);
                    mul_req.b = MUL_W'(r_k[K_W-1:32]);
                end
                default: mul_req = '0;
            endcase
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_alpha <= ALPHA_RESET;
            r_count <= '0;
            r_rd    <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_rsq   <= '0;
            r_fb    <= SPK_W'(1);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= rd_en;
            r_v2    <= r_v1;
            r_done  <= finish;
            if (cfg_wr && paddr[2] == REG_ALPHA) begin
                r_alpha <= pwdata;
            end
            if (accept && !full) begin
                r_count <= r_count + 1'b1;
            end
            if (accept && i_last) begin
                r_rd  <= '0;
                r_rsq <= '0;
                r_fb  <= SPK_W'(1);
            end
            if (rd_en && !last_issue) begin
                r_rd <= r_rd + 1'b1;
            end
            if (r_state == ST_DRAIN && drained && r_spk != '0) begin
                r_fb <= r_spk;
            end
            if (crit_done && !finish) begin
                r_rd  <= '0;
                r_rsq <= r_rsq + 1'b1;
            end
            if (finish) begin
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_s2_spk <= rd_cell.spikes;
            r_s2_occ <= rd_cell.occ;
        end
        if ((accept && i_last) || (crit_done && !finish)) begin
            r_spk <= '0;
            r_occ <= '0;
        end else if (r_v2 && in_range) begin
            r_spk <= spk_next;
            r_occ <= occ_next;
        end
        if (r_state == ST_M1) begin
            r_k <= prod[K_W-1:0];
        end
        if (r_state == ST_PP0) begin
            r_p2 <= prod[P2_W-1:0];
        end
        if (r_state == ST_PP1) begin
            r_acc <= ACC_W'(prod);
        end else if (r_state == ST_PP2 || r_state == ST_PP3) begin
            r_acc <= r_acc + {prod[ACC_W-33:0], 32'b0};
        end
        if (finish) begin
            r_out_spk <= r_spk;
            r_out_occ <= r_occ;
            r_out_met <= crit_met;
            r_out_rsq <= r_rsq;
        end
    end

    assign o_done            = r_done;
    assign o_spike_sum       = r_out_spk;
    assign o_occupancy_sum   = r_out_occ;
    assign o_criterion_met   = r_out_met;
    assign o_final_radius_sq = r_out_rsq;
    assign prdata            = (paddr[2] == REG_ALPHA) ? r_alpha : '0;
    assign pready            = 1'b1;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result strobe without a finished search");

    a_rsq_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (9'(o_final_radius_sq) < 9'(RADIUS_SQ_LIMIT)))
        else $error("final radius beyond limit");

    a_limit_when_unmet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_criterion_met) |-> (9'(o_final_radius_sq) == 9'(RADIUS_SQ_LIMIT - 1)))
        else $error("search stopped early without meeting the criterion");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_count <= CW'(GRID_CELLS)))
        else $error("cell count beyond grid size");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_count == '0))
        else $error("cell count not cleared after result");

endmodule

// ===== sv/arbu_mult.sv =====
module arbu_mult
    import arbu_pkg::*;
(
    input  logic              i_clk,
    input  t_mul_req          i_req,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_req.a * i_req.b;
    end

    assign o_prod = r_prod;

endmodule

// ===== sv/arbu_cell_mem.sv =====
module arbu_cell_mem
    import arbu_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_cell         i_wr_cell,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_cell         o_rd_cell
);

    t_cell r_mem [DEPTH];
    t_cell r_rd_cell;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_cell <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_cell = r_rd_cell;

endmodule

// ===== test/arbu_checker.sv =====
module arbu_checker
    import arbu_pkg::*;
#(
    parameter int GRID_CELLS      = 4096,
    parameter int RADIUS_SQ_LIMIT = 200
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                start,
    input  logic                busy,
    input  logic [DIST_W-1:0]   i_distance,
    input  logic [SPK_IN_W-1:0] i_spikes,
    input  logic [OCC_IN_W-1:0] i_occupancy,
    input  logic                i_last,

    input  logic                o_done,
    input  logic [SPK_W-1:0]    o_spike_sum,
    input  logic [OCC_W-1:0]    o_occupancy_sum,
    input  logic                o_criterion_met,
    input  logic [RSQ_W-1:0]    o_final_radius_sq,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic [PDATA_W-1:0]  prdata,
    input  logic                pready,

    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct {
        logic [SPK_W-1:0] spk;
        logic [OCC_W-1:0] occ;
        logic             met;
        logic [RSQ_W-1:0] rsq;
    } t_bin_result;

    t_cell              grid_q[$];
    t_bin_result        expected_bins[$];
    logic [ALPHA_W-1:0] alpha_copy = ALPHA_RESET;
    int                 n_fail = 0;

    // exact test of (alpha*occ)^2 * rsq * fallback > 2^56, wide enough to never wrap
    function automatic bit over_threshold(input logic [ALPHA_W-1:0] a,
                                          input logic [OCC_W-1:0] occ,
                                          input int unsigned rsq,
                                          input logic [SPK_W-1:0] fb);
        logic [199:0] aw, ow, rw, fw, p, lim;
        aw  = a;
        ow  = occ;
        rw  = rsq;
        fw  = fb;
        lim = 1;
        lim = lim << 56;
        p   = aw * ow;
        p   = p * p;
        p   = p * rw;
        p   = p * fw;
        return p > lim;
    endfunction

    // radius search over the cells stored since the previous search
    function automatic t_bin_result predict_bin(input logic [ALPHA_W-1:0] a);
        t_bin_result      r;
        logic [SPK_W:0]   spk;
        logic [OCC_W:0]   occ;
        logic [SPK_W-1:0] fb;
        logic [31:0]      d2, lim;
        int unsigned      rsq;
        bit               stop;
        fb    = 1;
        rsq   = 0;
        stop  = 0;
        r.met = 1'b0;
        while (!stop) begin
            lim = rsq << 16;
            spk = '0;
            occ = '0;
            foreach (grid_q[c]) begin
                d2 = grid_q[c].distance * grid_q[c].distance;
                if (d2 <= lim) begin
                    spk = spk + grid_q[c].spikes;
                    occ = occ + grid_q[c].occ;
                    if (spk > SPK_MAX) spk = SPK_MAX;
                    if (occ > OCC_MAX) occ = OCC_MAX;
                end
            end
            if (spk != 0) fb = spk[SPK_W-1:0];
            r.spk = spk[SPK_W-1:0];
            r.occ = occ[OCC_W-1:0];
            r.rsq = rsq[RSQ_W-1:0];
            if (over_threshold(a, r.occ, rsq, fb)) begin
                r.met = 1'b1;
                stop  = 1;
            end else if (rsq == RADIUS_SQ_LIMIT - 1) begin
                stop = 1;
            end else begin
                rsq++;
            end
        end
        return r;
    endfunction

    task automatic note_fail(input string msg);
        n_fail++;
        if (n_fail <= 10) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        t_bin_result want;
        if (!i_rst_n) begin
            grid_q.delete();
            expected_bins.delete();
            alpha_copy = ALPHA_RESET;
        end else begin
            if (psel && penable && pready && paddr[2] == REG_ALPHA) begin
                if (pwrite) begin
                    alpha_copy = pwdata;
                end else if (prdata !== alpha_copy) begin
                    note_fail($sformatf("alpha readback: exp %h got %h", alpha_copy, prdata));
                end
            end

            if (o_done) begin
                if (expected_bins.size() == 0) begin
                    note_fail("bin result with no request outstanding");
                end else begin
                    want = expected_bins.pop_front();
                    if (o_spike_sum !== want.spk || o_occupancy_sum !== want.occ ||
                        o_criterion_met !== want.met || o_final_radius_sq !== want.rsq) begin
                        note_fail($sformatf(
                            "bin mismatch (exp/got): spk %0d/%0d occ %0d/%0d met %0d/%0d rsq %0d/%0d",
                            want.spk, o_spike_sum, want.occ, o_occupancy_sum,
                            want.met, o_criterion_met, want.rsq, o_final_radius_sq));
                    end
                end
            end

            if (start && !busy) begin
                // cells beyond a full grid are dropped, but last still fires the search
                if (grid_q.size() < GRID_CELLS)
                    grid_q.push_back({i_distance, i_spikes, i_occupancy});
                if (i_last) begin
                    expected_bins.push_back(predict_bin(alpha_copy));
                    grid_q.delete();
                end
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= expected_bins.size();
    end

endmodule

// ===== test/tb.sv =====
module tb;
    import arbu_pkg::*;

    localparam int GRID_CELLS      = 4096;
    localparam int RADIUS_SQ_LIMIT = 200;
    localparam int WATCHDOG_LIMIT  = 100000;
    localparam int RANDOM_ITEMS    = 550;
    localparam int N_PHASES        = 8;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [DIST_W-1:0]   i_distance = '0;
    logic [SPK_IN_W-1:0] i_spikes = '0;
    logic [OCC_IN_W-1:0] i_occupancy = '0;
    logic                i_last = 1'b0;
    logic                o_done;
    logic [SPK_W-1:0]    o_spike_sum;
    logic [OCC_W-1:0]    o_occupancy_sum;
    logic                o_criterion_met;
    logic [RSQ_W-1:0]    o_final_radius_sq;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;
    bit                  gaps_on = 1;
    int                  items_sent = 0;
    int                  idle_cycles;
    logic [ALPHA_W-1:0]  alpha_plan [N_PHASES];

    adaptive_radius_binning_unit #(
        .GRID_CELLS      (GRID_CELLS),
        .RADIUS_SQ_LIMIT (RADIUS_SQ_LIMIT)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_distance        (i_distance),
        .i_spikes          (i_spikes),
        .i_occupancy       (i_occupancy),
        .i_last            (i_last),
        .o_done            (o_done),
        .o_spike_sum       (o_spike_sum),
        .o_occupancy_sum   (o_occupancy_sum),
        .o_criterion_met   (o_criterion_met),
        .o_final_radius_sq (o_final_radius_sq),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    arbu_checker #(
        .GRID_CELLS      (GRID_CELLS),
        .RADIUS_SQ_LIMIT (RADIUS_SQ_LIMIT)
    ) bin_monitor (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_distance        (i_distance),
        .i_spikes          (i_spikes),
        .i_occupancy       (i_occupancy),
        .i_last            (i_last),
        .o_done            (o_done),
        .o_spike_sum       (o_spike_sum),
        .o_occupancy_sum   (o_occupancy_sum),
        .o_criterion_met   (o_criterion_met),
        .o_final_radius_sq (o_final_radius_sq),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic pause();
        int g;
        g = 0;
        if (gaps_on) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: g = 0;
                5, 6, 7, 8:    g = $urandom_range(1, 3);
                default:       g = $urandom_range(10, 40);
            endcase
        end
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_cell(input logic [DIST_W-1:0] d, input logic [SPK_IN_W-1:0] s,
                             input logic [OCC_IN_W-1:0] o, input logic l);
        start       <= 1'b1;
        i_distance  <= d;
        i_spikes    <= s;
        i_occupancy <= o;
        i_last      <= l;
        do @(posedge i_clk); while (busy);
        items_sent++;
        pause();
    endtask

    // block idle: no bin result outstanding and search finished
    task automatic wait_quiet();
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic reg_access(input logic wr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= '0;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_alpha(input logic [ALPHA_W-1:0] a);
        reg_access(1'b1, a);
        reg_access(1'b0, '0);
    endtask

    task automatic send_random_grid(input int n);
        logic [DIST_W-1:0]   d;
        logic [SPK_IN_W-1:0] s;
        logic [OCC_IN_W-1:0] o;
        int                  k;
        for (int c = 0; c < n; c++) begin
            k = $urandom_range(0, 14);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: d = DIST_W'($urandom_range(0, 16'h0F00));
                6:                d = DIST_W'(k << 8);             // exactly on a radius boundary
                7:                d = DIST_W'(((k + 1) << 8) - 1); // just inside the next one
                default:          d = DIST_W'($urandom);
            endcase
            case ($urandom_range(0, 19))
                0, 1, 2:    s = '0;
                3, 4, 5, 6, 7, 8, 9, 10, 11: s = SPK_IN_W'($urandom_range(0, 255));
                default:    s = SPK_IN_W'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:          o = '0;
                1, 2, 3:    o = OCC_IN_W'($urandom_range(0, 255));
                4, 5, 6:    o = OCC_IN_W'($urandom_range(0, 12'hFFF));
                default:    o = OCC_IN_W'($urandom);
            endcase
            send_cell(d, s, o, c == n - 1);
        end
    endtask

    initial begin
        int n, first;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset value of alpha
        reg_access(1'b0, '0);

        // empty sums: never meets, runs to the radius limit
        send_cell(16'h0000, 16'h0000, 24'h000000, 1'b1);
        // A exactly 1.0: k = 1 fails, k = 2 passes
        send_cell(16'h0100, 16'h0001, 24'h001000, 1'b1);
        // zero spikes, positive occupancy keeps fallback at 1
        send_cell(16'h0000, 16'h0000, 24'h000400, 1'b1);
        // field extremes and radius boundaries
        send_cell(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0);
        send_cell(16'h0101, 16'h0000, 24'h000800, 1'b0);
        send_cell(16'h0000, 16'h8000, 24'h000001, 1'b0);
        send_cell(16'h0E24, 16'h0003, 24'h000010, 1'b0);
        send_cell(16'h0E25, 16'h00FF, 24'h7FFFFF, 1'b1);
        wait_quiet();

        set_alpha('0);
        send_cell(16'h0000, 16'hFFFF, 24'hFFFFFF, 1'b0);
        send_cell(16'h0200, 16'h0001, 24'h000001, 1'b1);
        wait_quiet();

        set_alpha('1);
        send_cell(16'h0000, 16'h0001, 24'h000001, 1'b0);
        send_cell(16'h0300, 16'h0010, 24'h000100, 1'b1);
        wait_quiet();

        set_alpha(32'h0000_0001);
        send_cell(16'h0080, 16'h0100, 24'hFFFFFF, 1'b0);
        send_cell(16'h0C00, 16'h0004, 24'h001000, 1'b1);
        wait_quiet();

        alpha_plan[0] = 32'h0001_0000;
        alpha_plan[1] = 32'h0000_0100;
        alpha_plan[2] = 32'hFFFF_FFFF;
        alpha_plan[3] = 32'h0000_0001;
        alpha_plan[4] = $urandom;
        alpha_plan[5] = 32'h0100_0000;
        alpha_plan[6] = 32'h0000_0000;
        alpha_plan[7] = $urandom_range(0, 32'h0004_0000);

        for (int p = 0; p < N_PHASES; p++) begin
            set_alpha(alpha_plan[p]);
            first = items_sent;
            while (items_sent - first < RANDOM_ITEMS / N_PHASES) begin
                gaps_on = ($urandom_range(0, 3) != 0);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                send_random_grid(n);
            end
            gaps_on = 1;
            wait_quiet();
        end

        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // a search may legally run with no request moving; only WATCHDOG_LIMIT idle cycles in a row fail the run
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_done || (psel && penable)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
